FILE: rtl/core/ldsw_pkg.sv
// shared types, constants and segment encoding for the led digit serial writer
package ldsw_pkg;

  localparam int DIGIT_COUNT_DEF = 4;
  localparam int STEP_W = 5;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int SEG_CODES = 18;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_WRITE_ALL = 2'd1;
  localparam logic [1:0] OP_WRITE_ONE = 2'd2;

  localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [2:0] REG_AUTO_COMMAND = 3'd1;
  localparam logic [2:0] REG_FIXED_COMMAND = 3'd2;
  localparam logic [2:0] REG_ADDR_COMMAND = 3'd3;
  localparam logic [2:0] REG_ACK_LIMIT = 3'd4;

  localparam logic [2:0] BRIGHTNESS_RST = 3'd2;
  localparam logic [7:0] AUTO_COMMAND_RST = 8'h40;
  localparam logic [7:0] FIXED_COMMAND_RST = 8'h44;
  localparam logic [7:0] ADDR_COMMAND_RST = 8'hc0;
  localparam logic [7:0] ACK_LIMIT_RST = 8'd200;

  localparam logic [7:0] DISPLAY_CMD_BASE = 8'h88;
  localparam logic [7:0] FIXED_ADDR_BASE = 8'hc0;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  localparam logic [7:0] SEG_ROM [SEG_CODES] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f,
    8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71, 8'h40, 8'h00
  };

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] digit_a;
    logic [7:0] digit_b;
    logic [7:0] digit_c;
    logic [7:0] digit_d;
    logic [1:0] position;
    logic       raw_segments;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic scl;
    logic sda_drive;
    logic sda_level;
    logic busy_res;
    logic frame_done;
  } out_item_t;

  typedef struct packed {
    logic [2:0] brightness;
    logic [7:0] auto_command;
    logic [7:0] fixed_command;
    logic [7:0] addr_command;
    logic [7:0] ack_limit;
  } cfg_t;

  function automatic logic [7:0] seg_encode(input logic [7:0] code, input logic raw);
    logic [7:0] seg;
    if (raw) begin
      seg = code;
    end else if (code < 8'(SEG_CODES)) begin
      seg = SEG_ROM[code[4:0]];
    end else begin
      seg = SEG_BLANK;
    end
    return seg;
  endfunction

endpackage

FILE: rtl/core/led_digit_serial_writer_unit.sv
// top level of the led digit serial writer: request register, wire sequencer, result register
//
// Each input request is one wire step toward a two-wire LED digit controller: a write request
// (four digits at auto-increment addresses, or one digit at a fixed address) is latched and the
// following tick requests play out the data command, address and digit bytes and display command
// frames, one line change per request, with an ack wait after every byte. The block takes one
// request per clock cycle while out_stall does not hold it and gives one result per request: the
// request sits in an input register, the sequencer computes its next state in one pass and the
// line levels land in the result register. Requests keep flowing while a result waits on
// out_stall, until both registers are full. Digit bytes are held in flip-flops, DIGIT_COUNT + 1
// entries deep. Configuration registers sit at byte address 4*i on the APB-style port.
module led_digit_serial_writer_unit #(
  parameter int DIGIT_COUNT = ldsw_pkg::DIGIT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ldsw_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ldsw_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ldsw_pkg::PADDR_W-1:0]  paddr,
  input  logic [ldsw_pkg::PDATA_W-1:0]  pwdata,
  output logic [ldsw_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  ldsw_pkg::in_item_t  in_data_r;
  logic                in_valid_r, in_valid_nxt;
  ldsw_pkg::out_item_t out_data_r;
  logic                out_valid_r, out_valid_nxt;
  ldsw_pkg::out_item_t seq_res;
  ldsw_pkg::cfg_t      cfg;
  logic                out_free;
  logic                fire;
  logic                accept;

  assign out_free = !out_valid_r || !out_stall;
  assign fire = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign accept = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= seq_res;
    end
  end

  ldsw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  ldsw_seq #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fire),
    .item    (in_data_r),
    .cfg     (cfg),
    .res     (seq_res)
  );

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
  assign pready = 1'b1;

endmodule

FILE: rtl/core/ldsw_cfg.sv
// apb configuration registers
module ldsw_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ldsw_pkg::PADDR_W-1:0]  paddr,
  input  logic [ldsw_pkg::PDATA_W-1:0]  pwdata,
  output logic [ldsw_pkg::PDATA_W-1:0]  prdata,
  output ldsw_pkg::cfg_t                cfg
);

  ldsw_pkg::cfg_t cfg_r;
  ldsw_pkg::cfg_t cfg_nxt;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        ldsw_pkg::REG_BRIGHTNESS:    cfg_nxt.brightness = pwdata[2:0];
        ldsw_pkg::REG_AUTO_COMMAND:  cfg_nxt.auto_command = pwdata[7:0];
        ldsw_pkg::REG_FIXED_COMMAND: cfg_nxt.fixed_command = pwdata[7:0];
        ldsw_pkg::REG_ADDR_COMMAND:  cfg_nxt.addr_command = pwdata[7:0];
        ldsw_pkg::REG_ACK_LIMIT:     cfg_nxt.ack_limit = pwdata[7:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ldsw_pkg::REG_BRIGHTNESS:    prdata = {29'd0, cfg_r.brightness};
      ldsw_pkg::REG_AUTO_COMMAND:  prdata = {24'd0, cfg_r.auto_command};
      ldsw_pkg::REG_FIXED_COMMAND: prdata = {24'd0, cfg_r.fixed_command};
      ldsw_pkg::REG_ADDR_COMMAND:  prdata = {24'd0, cfg_r.addr_command};
      ldsw_pkg::REG_ACK_LIMIT:     prdata = {24'd0, cfg_r.ack_limit};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness <= ldsw_pkg::BRIGHTNESS_RST;
      cfg_r.auto_command <= ldsw_pkg::AUTO_COMMAND_RST;
      cfg_r.fixed_command <= ldsw_pkg::FIXED_COMMAND_RST;
      cfg_r.addr_command <= ldsw_pkg::ADDR_COMMAND_RST;
      cfg_r.ack_limit <= ldsw_pkg::ACK_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/ldsw_seq.sv
// wire sequencer: frame, byte, bit and ack-wait state advanced one wire step per request
module ldsw_seq #(
  parameter int DIGIT_COUNT = ldsw_pkg::DIGIT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  ldsw_pkg::in_item_t  item,
  input  ldsw_pkg::cfg_t      cfg,
  output ldsw_pkg::out_item_t res
);

  localparam int DEPTH = DIGIT_COUNT + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int SW = ldsw_pkg::STEP_W;

  localparam logic [2:0] PH_BIT_SET     = 3'd0;
  localparam logic [2:0] PH_BIT_HIGH    = 3'd1;
  localparam logic [2:0] PH_BIT_LOW     = 3'd2;
  localparam logic [2:0] PH_ACK_SET     = 3'd3;
  localparam logic [2:0] PH_ACK_HIGH    = 3'd4;
  localparam logic [2:0] PH_ACK_LOW     = 3'd5;
  localparam logic [2:0] PH_ACK_RELEASE = 3'd6;

  localparam logic [2:0] PH_COND_0 = 3'd0;
  localparam logic [2:0] PH_COND_1 = 3'd1;
  localparam logic [2:0] PH_COND_2 = 3'd2;

  logic [SW-1:0] step_r, step_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [7:0]    ack_r, ack_nxt;
  logic          mode_r, mode_nxt;
  logic          scl_r, scl_nxt;
  logic          drv_r, drv_nxt;
  logic          lvl_r, lvl_nxt;
  logic [7:0]    store_r [DEPTH];
  logic [7:0]    store_nxt [DEPTH];

  logic [SW-1:0]    elem;
  logic [SW-1:0]    nbytes;
  logic [SW-1:0]    dig_off;
  logic [IDX_W-1:0] store_idx;
  logic             is_start, is_stop, is_cmd, is_dig, is_disp;
  logic             last_elem;
  logic [SW-1:0]    adv_step;
  logic [7:0]       byte_val;
  logic [7:0]       ack_inc;
  logic [7:0]       digits [4];
  logic             done;

  assign elem = step_r - SW'(1);
  assign nbytes = mode_r ? SW'(1) : SW'(DIGIT_COUNT);
  assign dig_off = elem - SW'(4);
  assign store_idx = dig_off[IDX_W-1:0];

  assign is_start = (elem == SW'(0)) || (elem == SW'(3)) || (elem == SW'(6) + nbytes);
  assign is_stop = (elem == SW'(2)) || (elem == SW'(5) + nbytes) || (elem == SW'(8) + nbytes);
  assign is_cmd = (elem == SW'(1));
  assign is_dig = (elem >= SW'(4)) && (elem <= SW'(4) + nbytes);
  assign is_disp = (elem == SW'(7) + nbytes);

  assign last_elem = (elem >= SW'(8) + nbytes);
  assign adv_step = last_elem ? '0 : step_r + SW'(1);
  assign ack_inc = ack_r + 8'd1;

  always_comb begin
    if (is_cmd) begin
      byte_val = mode_r ? cfg.fixed_command : cfg.auto_command;
    end else if (is_dig) begin
      byte_val = store_r[store_idx];
    end else if (is_disp) begin
      byte_val = ldsw_pkg::DISPLAY_CMD_BASE | {5'd0, cfg.brightness};
    end else begin
      byte_val = 8'd0;
    end
  end

  assign digits[0] = item.digit_a;
  assign digits[1] = item.digit_b;
  assign digits[2] = item.digit_c;
  assign digits[3] = item.digit_d;

  always_comb begin
    step_nxt = step_r;
    phase_nxt = phase_r;
    bit_nxt = bit_r;
    shift_nxt = shift_r;
    ack_nxt = ack_r;
    mode_nxt = mode_r;
    scl_nxt = scl_r;
    drv_nxt = drv_r;
    lvl_nxt = lvl_r;
    store_nxt = store_r;
    done = 1'b0;
    if (step_en) begin
      if (step_r != '0) begin
        if (is_start || is_stop) begin
          phase_nxt = phase_r + 3'd1;
          case (phase_r)
            PH_COND_0: begin
              if (is_start) begin
                scl_nxt = 1'b1;
              end else begin
                drv_nxt = 1'b1;
                lvl_nxt = 1'b0;
              end
            end
            PH_COND_1: begin
              if (is_start) begin
                drv_nxt = 1'b1;
                lvl_nxt = 1'b1;
              end else begin
                scl_nxt = 1'b0;
              end
            end
            PH_COND_2: begin
              if (is_start) begin
                drv_nxt = 1'b1;
                lvl_nxt = 1'b0;
              end else begin
                scl_nxt = 1'b1;
              end
            end
            default: begin
              if (is_start) begin
                scl_nxt = 1'b0;
              end else begin
                drv_nxt = 1'b1;
                lvl_nxt = 1'b1;
              end
              phase_nxt = '0;
              bit_nxt = '0;
              step_nxt = adv_step;
              done = last_elem;
            end
          endcase
        end else if (is_cmd || is_dig || is_disp) begin
          case (phase_r)
            PH_BIT_SET: begin
              drv_nxt = 1'b1;
              if (bit_r == '0) begin
                shift_nxt = byte_val;
                lvl_nxt = byte_val[0];
              end else begin
                lvl_nxt = shift_r[0];
              end
              phase_nxt = PH_BIT_HIGH;
            end
            PH_BIT_HIGH: begin
              scl_nxt = 1'b1;
              phase_nxt = PH_BIT_LOW;
            end
            PH_BIT_LOW: begin
              scl_nxt = 1'b0;
              shift_nxt = {1'b0, shift_r[7:1]};
              if (bit_r == 3'd7) begin
                bit_nxt = '0;
                phase_nxt = PH_ACK_SET;
              end else begin
                bit_nxt = bit_r + 3'd1;
                phase_nxt = PH_BIT_SET;
              end
            end
            PH_ACK_SET: begin
              drv_nxt = 1'b1;
              lvl_nxt = 1'b1;
              phase_nxt = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
              scl_nxt = 1'b1;
              phase_nxt = PH_ACK_LOW;
            end
            PH_ACK_LOW: begin
              scl_nxt = 1'b0;
              phase_nxt = PH_ACK_RELEASE;
            end
            PH_ACK_RELEASE: begin
              drv_nxt = 1'b0;
              ack_nxt = '0;
              phase_nxt = phase_r + 3'd1;
            end
            default: begin
              if (!item.sda_in) begin
                drv_nxt = 1'b1;
                ack_nxt = '0;
                phase_nxt = '0;
                bit_nxt = '0;
                step_nxt = adv_step;
                done = last_elem;
              end else if (ack_inc == cfg.ack_limit) begin
                drv_nxt = 1'b1;
                lvl_nxt = 1'b0;
                ack_nxt = '0;
              end else begin
                drv_nxt = 1'b0;
                ack_nxt = ack_inc;
              end
            end
          endcase
        end else begin
          phase_nxt = '0;
          bit_nxt = '0;
          step_nxt = '0;
          done = 1'b1;
        end
      end else if (item.op == ldsw_pkg::OP_WRITE_ALL) begin
        mode_nxt = 1'b0;
        store_nxt[0] = cfg.addr_command;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          if (i < 4) begin
            store_nxt[IDX_W'(i + 1)] = ldsw_pkg::seg_encode(digits[2'(i)], item.raw_segments);
          end else begin
            store_nxt[IDX_W'(i + 1)] = ldsw_pkg::SEG_BLANK;
          end
        end
        step_nxt = SW'(1);
        phase_nxt = '0;
        bit_nxt = '0;
        ack_nxt = '0;
      end else if (item.op == ldsw_pkg::OP_WRITE_ONE) begin
        mode_nxt = 1'b1;
        store_nxt[0] = ldsw_pkg::FIXED_ADDR_BASE | {6'd0, item.position};
        store_nxt[1] = ldsw_pkg::seg_encode(item.digit_a, item.raw_segments);
        step_nxt = SW'(1);
        phase_nxt = '0;
        bit_nxt = '0;
        ack_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      phase_r <= '0;
      bit_r <= '0;
      ack_r <= '0;
      mode_r <= 1'b0;
      scl_r <= 1'b1;
      drv_r <= 1'b1;
      lvl_r <= 1'b1;
    end else begin
      step_r <= step_nxt;
      phase_r <= phase_nxt;
      bit_r <= bit_nxt;
      ack_r <= ack_nxt;
      mode_r <= mode_nxt;
      scl_r <= scl_nxt;
      drv_r <= drv_nxt;
      lvl_r <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    store_r <= store_nxt;
  end

  assign res.scl = scl_nxt;
  assign res.sda_drive = drv_nxt;
  assign res.sda_level = lvl_nxt;
  assign res.busy_res = (step_nxt != '0);
  assign res.frame_done = done;

endmodule

FILE: rtl/core/ldsw_chk.sv
// port-level checker for the led digit serial writer, bound to the top level
module ldsw_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input ldsw_pkg::out_item_t           out_data
);

  // end of the final stop leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |-> !out_data.busy_res)
    else $error("frame_done while still busy");

  // when idle both lines rest high and driven
  a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.busy_res |->
      out_data.scl && out_data.sda_drive && out_data.sda_level)
    else $error("lines not released high while idle");

  // data line is released only inside a sequence
  a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.sda_drive |-> out_data.busy_res)
    else $error("sda released while idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind led_digit_serial_writer_unit ldsw_chk u_ldsw_chk (.*);
